>>> rtl/core/tsphc_pkg.sv
// tsphc_pkg: shared types and constants of the transport stream header checker
// holds the table size, status codes and the token that walks the cell chain
// no dependencies
package tsphc_pkg;

	localparam int TABLE_SIZE = 64;
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

	localparam logic [7:0]  SYNC_VALUE = 8'h47;
	localparam logic [12:0] NULL_PID   = 13'h1FFF;
	localparam logic [7:0]  BODY_BYTES = 8'd184;
	localparam logic [7:0]  MAX_ALEN   = 8'd183;
	localparam logic [7:0]  HDR_BYTES  = 8'd4;

	typedef enum logic [3:0] {
		ST_PASS      = 4'd0,
		ST_NULL      = 4'd1,
		ST_DUP       = 4'd2,
		ST_BAD_SYNC  = 4'd3,
		ST_TEI       = 4'd4,
		ST_RSVD_CTRL = 4'd5,
		ST_BAD_ALEN  = 4'd6,
		ST_GAP       = 4'd7,
		ST_HALTED    = 4'd8
	} status_t;

	// lookup token handed from cell to cell
	typedef struct packed {
		logic        active;
		logic [12:0] pid;
		logic [3:0]  cc;
		logic        disc;
		logic        done;
		logic        dup;
		logic        gap;
		logic        alloc;
	} token_t;

endpackage

>>> rtl/core/tsphc_cell.sv
// tsphc_cell: one continuity counter table entry plus its token stage
// depends on tsphc_pkg (token_t)
module tsphc_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  tsphc_pkg::token_t tok_in,
	input  logic             in_use,
	input  logic             is_next,
	output tsphc_pkg::token_t tok_out
);
	import tsphc_pkg::*;

	logic [12:0] pid_q;
	logic [3:0]  last_q;
	logic        known_q;
	token_t      tok_q;

	logic   probe, hit, grab, chk, dup, gap;
	token_t tok_d;

	always_comb begin
		probe = tok_in.active && !tok_in.done;
		hit   = probe && in_use && (pid_q == tok_in.pid);
		grab  = probe && is_next;
		// discontinuity skips the check against the known counter
		chk   = hit && known_q && !tok_in.disc;
		dup   = chk && (tok_in.cc == last_q);
		gap   = chk && !dup && (tok_in.cc != 4'(last_q + 4'd1));
		tok_d = tok_in;
		if (hit || grab) begin
			tok_d.done  = 1'b1;
			tok_d.dup   = dup;
			tok_d.gap   = gap;
			tok_d.alloc = grab;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (grab) begin
			pid_q   <= tok_in.pid;
			last_q  <= tok_in.cc;
			known_q <= 1'b1;
		end else if (hit && !dup && !gap) begin
			last_q  <= tok_in.cc;
			known_q <= 1'b1;
		end
	end

	assign tok_out = tok_q;

	a_hit_grab_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit && grab)) else $error("cell both matched and allocated");

	a_flags_need_done: assert property (@(posedge clk) disable iff (!arst_n)
		tok_q.active && (tok_q.dup || tok_q.gap || tok_q.alloc) |-> tok_q.done)
		else $error("token result flag without done");

	a_dup_gap_excl: assert property (@(posedge clk) disable iff (!arst_n)
		tok_q.active |-> !(tok_q.dup && tok_q.gap))
		else $error("token both duplicate and gap");

	a_grab_writes: assert property (@(posedge clk) disable iff (!arst_n)
		grab |=> known_q && (last_q == $past(tok_in.cc)))
		else $error("allocated entry not recorded");

endmodule

>>> rtl/core/ts_packet_header_checker.sv
// ts_packet_header_checker: top level of the transport stream header checker
// depends on tsphc_pkg and tsphc_cell (chain of TABLE_SIZE table cells)
//
// usage
//  - input channel in_valid/in_stall carries one item per packet: the four
//    header bytes plus the adaptation length and flags bytes
//  - output channel out_valid/out_stall returns one item per input item:
//    status, pid, flags, payload offset and payload length
//  - one item is worked on at a time; in_stall is high while it is in flight
//  - packets with payload walk a lookup token through the chain of
//    TABLE_SIZE cells, one cell per cycle, and the result is then
//    registered from the token that leaves the chain
//  - packets without a table lookup (halted, errors, null, adaptation only)
//    go from the header check straight to the output register
//  - the chain walk sets the sustained rate: a new item is accepted only
//    after the last one has left for the output register
//  - a finished item sits in the output register; the next item is accepted
//    while it waits, and its result waits in turn while out_stall is high
//  - reset clears the halt flag and the entry count; table contents are not
//    cleared, entries beyond the count are never matched
//  - any error status sets a sticky halt; later items report halted
module ts_packet_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  sync_byte,
	input  logic [7:0]  hdr_byte1,
	input  logic [7:0]  hdr_byte2,
	input  logic [7:0]  hdr_byte3,
	input  logic [7:0]  adapt_length,
	input  logic [7:0]  adapt_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [12:0] pid,
	output logic        start_flag,
	output logic        payload_present,
	output logic        discontinuity,
	output logic        rand_access,
	output logic [7:0]  payload_offset,
	output logic [7:0]  payload_length
);
	import tsphc_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SCAN, S_DONE} state_t;

	state_t state_q;

	// captured input item
	logic [7:0] sync_q, b1_q, b2_q, b3_q, alen_q, aflags_q;

	// result being built
	status_t     res_status_q;
	logic [12:0] res_pid_q;
	logic        res_start_q, res_payload_q, res_disc_q, res_rnd_q;
	logic [7:0]  res_offset_q, res_plen_q;
	logic        alloc_q;

	// output register
	logic        out_valid_q;
	status_t     out_status_q;
	logic [12:0] out_pid_q;
	logic        out_start_q, out_payload_q, out_disc_q, out_rnd_q;
	logic [7:0]  out_offset_q, out_plen_q;

	logic             halted_q;
	logic [CNT_W-1:0] used_q;
	token_t           launch_q;

	// header decode of the captured item
	logic        tei, start, has_adapt, payload, disc, rnd, halt_set, out_free;
	logic [12:0] hdr_pid;
	logic [1:0]  afc;
	logic [3:0]  cc;

	// header check outcome
	status_t     ev_status;
	logic        ev_launch, ev_full, ev_echo;

	always_comb begin
		tei       = b1_q[7];
		start     = b1_q[6];
		hdr_pid   = {b1_q[4:0], b2_q};
		afc       = b3_q[5:4];
		cc        = b3_q[3:0];
		has_adapt = afc[1];
		payload   = afc[0];
		// flags count only when the adaptation field has a body
		disc      = has_adapt && (alen_q != 8'd0) && aflags_q[7];
		rnd       = has_adapt && (alen_q != 8'd0) && aflags_q[6];
		halt_set  = (res_status_q == ST_BAD_SYNC) || (res_status_q == ST_TEI) ||
		            (res_status_q == ST_RSVD_CTRL) || (res_status_q == ST_BAD_ALEN) ||
		            (res_status_q == ST_GAP);
		out_free  = !out_valid_q || !out_stall;
		// checks in order: halt, sync, null pid, error bit, control, length
		ev_launch = 1'b0;
		priority if (halted_q) begin
			ev_status = ST_HALTED;
		end else if (sync_q != SYNC_VALUE) begin
			ev_status = ST_BAD_SYNC;
		end else if (hdr_pid == NULL_PID) begin
			ev_status = ST_NULL;
		end else if (tei) begin
			ev_status = ST_TEI;
		end else if (afc == 2'd0) begin
			ev_status = ST_RSVD_CTRL;
		end else if (has_adapt && (alen_q > MAX_ALEN)) begin
			ev_status = ST_BAD_ALEN;
		end else begin
			ev_status = ST_PASS;
			ev_launch = payload;
		end
		// full fields on a good header, pid and start only on a null packet
		ev_full = (ev_status == ST_PASS);
		ev_echo = ev_full || (ev_status == ST_NULL);
	end

	// chain of table cells, the token enters at cell 0
	token_t tok_w [0:TABLE_SIZE];
	assign tok_w[0] = launch_q;

	for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_cell
		logic in_use, is_next;
		assign in_use  = CNT_W'(k) < used_q;
		assign is_next = CNT_W'(k) == used_q;
		tsphc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_w[k]),
			.in_use  (in_use),
			.is_next (is_next),
			.tok_out (tok_w[k+1])
		);
	end

	token_t tok_exit;
	assign tok_exit = tok_w[TABLE_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			out_valid_q     <= 1'b0;
			halted_q        <= 1'b0;
			used_q          <= '0;
			launch_q.active <= 1'b0;
		end else begin
			launch_q.active <= (state_q == S_EVAL) && ev_launch;
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sync_q   <= sync_byte;
						b1_q     <= hdr_byte1;
						b2_q     <= hdr_byte2;
						b3_q     <= hdr_byte3;
						alen_q   <= adapt_length;
						aflags_q <= adapt_flags;
						state_q  <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_status_q  <= ev_status;
					res_pid_q     <= ev_echo ? hdr_pid : '0;
					res_start_q   <= ev_echo && start;
					res_payload_q <= ev_full && payload;
					res_disc_q    <= ev_full && disc;
					res_rnd_q     <= ev_full && rnd;
					res_offset_q  <= !ev_full ? '0 :
					                 has_adapt ? 8'(HDR_BYTES + 8'd1 + alen_q) : HDR_BYTES;
					res_plen_q    <= !ev_full ? '0 :
					                 has_adapt ? 8'(MAX_ALEN - alen_q) : BODY_BYTES;
					alloc_q       <= 1'b0;
					// continuity check walks the cell chain
					launch_q.pid   <= hdr_pid;
					launch_q.cc    <= cc;
					launch_q.disc  <= disc;
					launch_q.done  <= 1'b0;
					launch_q.dup   <= 1'b0;
					launch_q.gap   <= 1'b0;
					launch_q.alloc <= 1'b0;
					state_q        <= ev_launch ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					if (tok_exit.active) begin
						alloc_q <= tok_exit.alloc;
						priority if (tok_exit.gap) begin
							res_status_q  <= ST_GAP;
							res_pid_q     <= '0;
							res_start_q   <= 1'b0;
							res_payload_q <= 1'b0;
							res_disc_q    <= 1'b0;
							res_rnd_q     <= 1'b0;
							res_offset_q  <= '0;
							res_plen_q    <= '0;
						end else if (tok_exit.dup) begin
							res_status_q <= ST_DUP;
						end else begin
							res_status_q <= ST_PASS;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= res_status_q;
						out_pid_q     <= res_pid_q;
						out_start_q   <= res_start_q;
						out_payload_q <= res_payload_q;
						out_disc_q    <= res_disc_q;
						out_rnd_q     <= res_rnd_q;
						out_offset_q  <= res_offset_q;
						out_plen_q    <= res_plen_q;
						if (halt_set) begin
							halted_q <= 1'b1;
						end
						if (alloc_q) begin
							used_q <= used_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign pid             = out_pid_q;
	assign start_flag      = out_start_q;
	assign payload_present = out_payload_q;
	assign discontinuity   = out_disc_q;
	assign rand_access     = out_rnd_q;
	assign payload_offset  = out_offset_q;
	assign payload_length  = out_plen_q;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt flag dropped");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_SIZE)) else $error("entry count beyond table");

	a_exit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_exit.active |-> state_q == S_SCAN) else $error("token left chain outside scan");

	a_alloc_only_pass: assert property (@(posedge clk) disable iff (!arst_n)
		tok_exit.active && tok_exit.alloc |-> !tok_exit.dup && !tok_exit.gap)
		else $error("new entry reported as duplicate or gap");

endmodule
